// ----- hdl/l2h_pkg.sv -----
// ----------------------------------------------------------------------------
// l2h_pkg
// Types, constants and the mix round shared by the lookup2 string hash unit.
// ----------------------------------------------------------------------------
package l2h_pkg;

  localparam logic [31:0] GOLDEN      = 32'h9e3779b9;
  localparam logic [3:0]  BLOCK_LEN   = 4'd12;
  localparam logic [3:0]  MIX_ROUNDS  = 4'd9;
  localparam int          QUEUE_DEPTH = 4;
  localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } l2h_abc_t;

  // One unit of work for the mixing side
  typedef struct packed {
    logic        start;       // first block of a message: reload a, b, c
    logic [7:0]  first_byte;  // initial c of the message
    l2h_abc_t    add;         // words added before the mix
    logic        double_mix;  // mix, add length to c, mix again
    logic        is_last;     // emit c after the mix
    logic [31:0] len;         // message length for the second mix
  } l2h_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MIX,
    BK_LEN,
    BK_EMIT
  } l2h_back_state_t;

  // One of the nine rounds of the lookup2 mix
  function automatic l2h_abc_t mix_round(l2h_abc_t v, logic [3:0] step);
    l2h_abc_t r;
    r = v;
    unique case (step)
      4'd0: r.a = (v.a - v.b - v.c) ^ (v.c >> 13);
      4'd1: r.b = (v.b - v.c - v.a) ^ (v.a << 8);
      4'd2: r.c = (v.c - v.a - v.b) ^ (v.b >> 13);
      4'd3: r.a = (v.a - v.b - v.c) ^ (v.c >> 12);
      4'd4: r.b = (v.b - v.c - v.a) ^ (v.a << 16);
      4'd5: r.c = (v.c - v.a - v.b) ^ (v.b >> 5);
      4'd6: r.a = (v.a - v.b - v.c) ^ (v.c >> 3);
      4'd7: r.b = (v.b - v.c - v.a) ^ (v.a << 10);
      4'd8: r.c = (v.c - v.a - v.b) ^ (v.b >> 15);
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/l2h_if.sv -----
// ----------------------------------------------------------------------------
// l2h_if
// Valid/ready channels for message bytes and hash results.
// ----------------------------------------------------------------------------
interface l2h_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output data_byte, output has_byte, output last,
                  input ready);
  modport sink   (input valid, input data_byte, input has_byte, input last,
                  output ready);
endinterface

interface l2h_hash_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

// ----- hdl/l2h_front.sv -----
// ----------------------------------------------------------------------------
// l2h_front
// Accepts bytes, packs twelve-byte blocks and builds work entries.
// ----------------------------------------------------------------------------
module l2h_front (
  input  logic                clk,
  input  logic                rst,
  l2h_byte_if.sink            msg,
  input  logic                q_full,
  output logic                push,
  output l2h_pkg::l2h_entry_t entry
);
  import l2h_pkg::*;

  logic [7:0]  bytes [BLOCK_LEN];
  logic [3:0]  fill;
  logic [31:0] length;
  logic        at_start;
  logic        first_pending;
  logic [7:0]  first_byte;

  logic        accept;
  logic [3:0]  fill_inc;
  logic [3:0]  cnt;
  logic        block_done;
  logic [31:0] len_next;
  logic [7:0]  bytes_eff [BLOCK_LEN];
  logic [7:0]  tail      [BLOCK_LEN];

  assign msg.ready = !q_full;
  assign accept    = msg.valid && msg.ready;

  // Merge the incoming byte and build block or tail words
  always_comb begin
    fill_inc   = fill + 4'd1;
    cnt        = msg.has_byte ? fill_inc : fill;
    block_done = msg.has_byte && (fill_inc == BLOCK_LEN);
    len_next   = length + 32'(msg.has_byte);
    for (int i = 0; i < BLOCK_LEN; i++) begin
      bytes_eff[i] = (msg.has_byte && fill == 4'(i)) ? msg.data_byte : bytes[i];
      tail[i]      = (4'(i) < cnt) ? bytes_eff[i] : 8'h00;
    end
    entry.start      = first_pending;
    entry.first_byte = at_start ? (msg.has_byte ? msg.data_byte : 8'h00) : first_byte;
    entry.double_mix = block_done && msg.last;
    entry.is_last    = msg.last;
    entry.len        = len_next;
    if (block_done) begin
      entry.add.a = {bytes_eff[3], bytes_eff[2], bytes_eff[1], bytes_eff[0]};
      entry.add.b = {bytes_eff[7], bytes_eff[6], bytes_eff[5], bytes_eff[4]};
      entry.add.c = {bytes_eff[11], bytes_eff[10], bytes_eff[9], bytes_eff[8]};
    end else begin
      entry.add.a = {tail[3], tail[2], tail[1], tail[0]};
      entry.add.b = {tail[7], tail[6], tail[5], tail[4]};
      entry.add.c = {tail[10], tail[9], tail[8], 8'h00} + len_next;
    end
    push = accept && (block_done || msg.last);
  end

  // Store bytes of the block being filled
  always_ff @(posedge clk) begin
    if (accept && msg.has_byte) begin
      bytes[fill] <= msg.data_byte;
      if (at_start) first_byte <= msg.data_byte;
    end
  end

  // Advance fill, length and message-start flags
  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      length        <= '0;
      at_start      <= 1'b1;
      first_pending <= 1'b1;
    end else if (accept) begin
      if (msg.has_byte) begin
        fill     <= block_done ? 4'd0 : fill_inc;
        length   <= len_next;
        at_start <= 1'b0;
      end
      if (push) first_pending <= 1'b0;
      if (msg.last) begin
        fill          <= '0;
        length        <= '0;
        at_start      <= 1'b1;
        first_pending <= 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill < BLOCK_LEN)
    else $error("block fill out of range");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && msg.last |=> fill == 4'd0 && length == 32'd0 && first_pending)
    else $error("message state not cleared after last item");
`endif

endmodule

// ----- hdl/l2h_queue.sv -----
// ----------------------------------------------------------------------------
// l2h_queue
// Short FIFO of work entries between the packing and mixing sides.
// ----------------------------------------------------------------------------
module l2h_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  l2h_pkg::l2h_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output l2h_pkg::l2h_entry_t head
);
  import l2h_pkg::*;

  l2h_entry_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QPTR_W:0]     count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rptr];

  // Write entry data
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_entry;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && empty))
    else $error("queue overflow or underflow");
`endif

endmodule

// ----- hdl/l2h_back.sv -----
// ----------------------------------------------------------------------------
// l2h_back
// Adds block words into a, b, c, runs the mix one round a cycle, emits c.
// ----------------------------------------------------------------------------
module l2h_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  input  l2h_pkg::l2h_entry_t head,
  output logic                pop,
  l2h_hash_if.source          hash
);
  import l2h_pkg::*;

  l2h_back_state_t state;
  l2h_back_state_t state_next;
  logic [3:0]      step;
  l2h_abc_t        abc;
  l2h_abc_t        base;
  logic            cur_double;
  logic            cur_last;
  logic [31:0]     cur_len;
  logic            out_valid;
  logic [31:0]     out_hash;
  logic            slot_free;

  assign slot_free       = !out_valid || hash.ready;
  assign hash.valid      = out_valid;
  assign hash.hash_value = out_hash;

  // Choose starting words for a new entry
  always_comb begin
    if (head.start) begin
      base.a = GOLDEN;
      base.b = GOLDEN;
      base.c = {24'h0, head.first_byte};
    end else begin
      base = abc;
    end
  end

  // Next state and pop
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = BK_MIX;
        end
      end
      BK_MIX: begin
        if (step == MIX_ROUNDS - 4'd1) begin
          priority if (cur_double) state_next = BK_LEN;
          else if (cur_last)       state_next = BK_EMIT;
          else                     state_next = BK_IDLE;
        end
      end
      BK_LEN:  state_next = BK_MIX;
      BK_EMIT: if (slot_free) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  // Datapath: load, mix rounds, length add
  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        if (pop) begin
          abc.a      <= base.a + head.add.a;
          abc.b      <= base.b + head.add.b;
          abc.c      <= base.c + head.add.c;
          cur_double <= head.double_mix;
          cur_last   <= head.is_last;
          cur_len    <= head.len;
          step       <= '0;
        end
      end
      BK_MIX: begin
        abc  <= mix_round(abc, step);
        step <= step + 4'd1;
      end
      BK_LEN: begin
        abc.c      <= abc.c + cur_len;
        cur_double <= 1'b0;
        step       <= '0;
      end
      BK_EMIT: ;
      default: ;
    endcase
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == BK_EMIT && slot_free) begin
      out_valid <= 1'b1;
    end else if (hash.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_EMIT && slot_free) out_hash <= abc.c;
  end

`ifndef NO_ASSERTIONS
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == BK_MIX |-> step < MIX_ROUNDS)
    else $error("mix round counter out of range");
  a_emit_last: assert property (@(posedge clk) disable iff (rst)
    state == BK_EMIT |-> cur_last && !cur_double)
    else $error("emit without a final entry");
`endif

endmodule

// ----- hdl/lookup2_string_hash_unit.sv -----
// ----------------------------------------------------------------------------
// lookup2_string_hash_unit
// Byte-serial lookup2 string hash: bytes in, one 32-bit hash per message out.
// ----------------------------------------------------------------------------
// The unit takes one byte item per cycle; input ready drops only while the
// queue is full. Bytes are packed into twelve-byte blocks; each completed
// block, and each message end, becomes an entry in a four-deep queue. The
// mixing side does one add and nine mix rounds per block on a single round
// unit, so a continuous byte stream runs at one byte per clock. A message end
// also loads the output register, waiting until the previous hash is taken;
// a last byte that completes a block adds the length to c between two mixes.
// Back-to-back short messages are limited by the round unit.
// ----------------------------------------------------------------------------
module lookup2_string_hash_unit (
  input  logic        clk,
  input  logic        rst,
  l2h_byte_if.sink    msg,
  l2h_hash_if.source  hash
);
  import l2h_pkg::*;

  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;
  l2h_entry_t push_entry;
  l2h_entry_t head;

  l2h_front u_front (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg),
    .q_full (q_full),
    .push   (push),
    .entry  (push_entry)
  );

  l2h_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head       (head)
  );

  l2h_back u_back (
    .clk   (clk),
    .rst   (rst),
    .empty (q_empty),
    .head  (head),
    .pop   (pop),
    .hash  (hash)
  );

endmodule
